// ===== hw/rtl/ps2kq_pkg.sv =====
// ps2kq_pkg: constants, types and keycode rom for the ps2 keycode queue
// no dependencies
`default_nettype none
package ps2kq_pkg;
  localparam int QueueDepthDefault = 256;
  localparam int RomSize = 89;

  localparam logic [7:0] ScanE0 = 8'he0;
  localparam logic [7:0] ScanE1 = 8'he1;
  localparam logic [6:0] CodeCtrl = 7'h1d;
  localparam logic [6:0] CodeCaps = 7'h3a;
  localparam logic [6:0] CodeLShift = 7'h2a;
  localparam logic [6:0] CodeRShift = 7'h36;
  localparam logic [6:0] CodeAlt = 7'h38;

  localparam logic ActScan = 1'b0;
  localparam logic ActPop = 1'b1;

  typedef struct packed {
    logic caps;
    logic e1;
    logic e0;
    logic alt;
    logic lshift;
    logic rshift;
    logic lctrl;
    logic rctrl;
  } mod_flags_t;

  typedef struct packed {
    logic       action;
    logic [7:0] scan_byte;
  } req_t;

  typedef struct packed {
    logic [15:0] key_out;
    logic        key_valid;
    logic        queue_empty;
    logic        key_queued;
    logic        overflow;
  } rsp_t;

  function automatic logic [63:0] rom_row(input logic [6:0] code);
    logic [63:0] r;
    r = '0;
    case (code)
      7'd1:  r = 64'h011b_011b_011b_01f0;
      7'd2:  r = 64'h0231_0221_0000_7800;
      7'd3:  r = 64'h0332_0340_0300_7900;
      7'd4:  r = 64'h0433_0423_0000_7a00;
      7'd5:  r = 64'h0534_0524_0000_7b00;
      7'd6:  r = 64'h0635_0625_0000_7c00;
      7'd7:  r = 64'h0736_075e_071e_7d00;
      7'd8:  r = 64'h0837_0826_0000_7e00;
      7'd9:  r = 64'h0938_092a_0000_7f00;
      7'd10: r = 64'h0a39_0a28_0000_8000;
      7'd11: r = 64'h0b30_0b29_0000_8100;
      7'd12: r = 64'h0c2d_0c5f_0c1f_8200;
      7'd13: r = 64'h0d3d_0d2b_0000_8300;
      7'd14: r = 64'h0e08_0e08_0e7f_0ef0;
      7'd15: r = 64'h0f09_0f00_9400_a5f0;
      7'd16: r = 64'h1071_1051_1011_1000;
      7'd17: r = 64'h1177_1157_1117_1100;
      7'd18: r = 64'h1265_1245_1205_1200;
      7'd19: r = 64'h1372_1352_1312_1300;
      7'd20: r = 64'h1474_1454_1414_1400;
      7'd21: r = 64'h1579_1559_1519_1500;
      7'd22: r = 64'h1675_1655_1615_1600;
      7'd23: r = 64'h1769_1749_1709_1700;
      7'd24: r = 64'h186f_184f_180f_1800;
      7'd25: r = 64'h1970_1950_1910_1900;
      7'd26: r = 64'h1a5b_1a7b_1a1b_1af0;
      7'd27: r = 64'h1b5d_1b7d_1b1d_1bf0;
      7'd28: r = 64'h1c0d_1c0d_1c0a_1cf0;
      7'd30: r = 64'h1e61_1e41_1e01_1e00;
      7'd31: r = 64'h1f73_1f53_1f13_1f00;
      7'd32: r = 64'h2064_2044_2004_2000;
      7'd33: r = 64'h2166_2146_2106_2100;
      7'd34: r = 64'h2267_2247_2207_2200;
      7'd35: r = 64'h2368_2348_2308_2300;
      7'd36: r = 64'h246a_244a_240a_2400;
      7'd37: r = 64'h256b_254b_250b_2500;
      7'd38: r = 64'h266c_264c_260c_2600;
      7'd39: r = 64'h273b_273a_0000_27f0;
      7'd40: r = 64'h2827_2822_0000_28f0;
      7'd41: r = 64'h2960_297e_0000_29f0;
      7'd43: r = 64'h2b5c_2b7c_2b1c_2bf0;
      7'd44: r = 64'h2c7a_2c5a_2c1a_2c00;
      7'd45: r = 64'h2d78_2d58_2d18_2d00;
      7'd46: r = 64'h2e63_2e43_2e03_2e00;
      7'd47: r = 64'h2f76_2f56_2f16_2f00;
      7'd48: r = 64'h3062_3042_3002_3000;
      7'd49: r = 64'h316e_314e_310e_3100;
      7'd50: r = 64'h326d_324d_320d_3200;
      7'd51: r = 64'h332c_333c_0000_33f0;
      7'd52: r = 64'h342e_343e_0000_34f0;
      7'd53: r = 64'h352f_353f_0000_35f0;
      7'd55: r = 64'h372a_372a_9600_37f0;
      7'd57: r = 64'h3920_3920_3920_3920;
      7'd59: r = 64'h3b00_5400_5e00_6800;
      7'd60: r = 64'h3c00_5500_5f00_6900;
      7'd61: r = 64'h3d00_5600_6000_6a00;
      7'd62: r = 64'h3e00_5700_6100_6b00;
      7'd63: r = 64'h3f00_5800_6200_6c00;
      7'd64: r = 64'h4000_5900_6300_6d00;
      7'd65: r = 64'h4100_5a00_6400_6e00;
      7'd66: r = 64'h4200_5b00_6500_6f00;
      7'd67: r = 64'h4300_5c00_6600_7000;
      7'd68: r = 64'h4400_5d00_6700_7100;
      7'd71: r = 64'h4700_4737_7700_0000;
      7'd72: r = 64'h4800_4838_8d00_0000;
      7'd73: r = 64'h4900_4939_8400_0000;
      7'd74: r = 64'h4a2d_4a2d_8e00_4af0;
      7'd75: r = 64'h4b00_4b34_7300_0000;
      7'd76: r = 64'h4c00_4c35_8f00_0000;
      7'd77: r = 64'h4d00_4d36_7400_0000;
      7'd78: r = 64'h4e2b_4e2b_9000_4ef0;
      7'd79: r = 64'h4f00_4f31_7500_0000;
      7'd80: r = 64'h5000_5032_9100_0000;
      7'd81: r = 64'h5100_5133_7600_0000;
      7'd82: r = 64'h5200_5230_9200_0000;
      7'd83: r = 64'h5300_532e_9300_0000;
      7'd86: r = 64'h565c_567c_0000_0000;
      7'd87: r = 64'h8500_8700_8900_8b00;
      7'd88: r = 64'h8600_8800_8a00_8c00;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ps2kq_if.sv =====
// ps2kq_if: valid/ready channel carrying one payload
// depends on nothing; payload type given by parameter
`default_nettype none
interface ps2kq_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ps2kq_decode.sv =====
// ps2kq_decode: scan byte to keycode translation and modifier tracking
// depends on ps2kq_pkg
`default_nettype none
module ps2kq_decode (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [7:0]             scan_byte,
  output      logic                   enq,
  output      logic [15:0]            keycode
);
  import ps2kq_pkg::*;

  mod_flags_t  flags;
  mod_flags_t  flags_next;
  logic        rel;
  logic [6:0]  code;
  logic [63:0] row;
  logic [7:0]  asc;
  logic        sh;
  logic        is_prefix;

  assign rel  = scan_byte[7];
  assign code = scan_byte[6:0];
  assign is_prefix = (scan_byte == ScanE0) || (scan_byte == ScanE1);
  assign row  = rom_row(code);
  assign asc  = row[55:48];

  always_comb begin
    flags_next = flags;
    enq = 1'b0;
    if (is_prefix) begin
      if (scan_byte == ScanE0) flags_next.e0 = 1'b1;
      else flags_next.e1 = 1'b1;
    end else if (!(flags.e1 && code == CodeCtrl)) begin
      flags_next.e0 = 1'b0;
      flags_next.e1 = 1'b0;
      case (code)
        CodeCaps:   if (rel) flags_next.caps = ~flags.caps;
        CodeLShift: flags_next.lshift = ~rel;
        CodeRShift: flags_next.rshift = ~rel;
        CodeCtrl: begin
          if (flags.e0) flags_next.rctrl = ~rel;
          else flags_next.lctrl = ~rel;
        end
        CodeAlt:    if (!flags.e1) flags_next.alt = ~rel;
        default:    enq = ~rel;
      endcase
    end
  end

  always_comb begin
    sh = flags.rshift | flags.lshift;
    if (flags.caps && asc >= 8'h61 && asc <= 8'h7a) sh = ~sh;
    if (flags.alt) keycode = row[15:0];
    else if (flags.rctrl | flags.lctrl) keycode = row[31:16];
    else if (sh) keycode = row[47:32];
    else keycode = row[63:48];
  end

  always_ff @(posedge clk) begin
    if (rst) flags <= '0;
    else if (step) flags <= flags_next;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ps2_scancode_to_keycode_queue.sv =====
// ps2_scancode_to_keycode_queue: top level, keycode ring queue in a memory
// depends on ps2kq_pkg, ps2kq_if, ps2kq_decode
//
// channel  dir  payload
// req      in   action, scan_byte
// rsp      out  key_out, key_valid, queue_empty, key_queued, overflow
//
// one request per cycle unless stalled; a response per request next cycle
// pop reads the memory (registered read) into the response register
// request accepted while the response register is empty or being taken
// reset clears modifiers, pointers and count; the memory is not cleared
`default_nettype none
module ps2_scancode_to_keycode_queue #(
  parameter int QUEUE_DEPTH = ps2kq_pkg::QueueDepthDefault
) (
  input wire logic clk,
  input wire logic rst,
  ps2kq_if.sink    req,
  ps2kq_if.source  rsp
);
  import ps2kq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

  logic [15:0]   mem [QUEUE_DEPTH];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count, count_next;
  logic          step, is_pop, enq, do_wr, do_rd;
  logic [15:0]   keycode, rd_data;
  logic          out_valid, out_popped;
  logic          out_qd, out_ovf, out_empty;

  assign step   = req.valid && req.ready;
  assign is_pop = req.payload.action == ActPop;
  assign req.ready = !out_valid || rsp.ready;

  ps2kq_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step && !is_pop),
    .scan_byte (req.payload.scan_byte),
    .enq       (enq),
    .keycode   (keycode)
  );

  assign do_wr = step && !is_pop && enq && (count != FullCnt);
  assign do_rd = step && is_pop && (count != '0);

  always_comb begin
    count_next = count;
    if (do_wr) count_next = count + 1'b1;
    else if (do_rd) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= keycode;
    if (do_rd) rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (do_wr) wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      if (step) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_popped <= do_rd;
      out_qd <= do_wr;
      out_ovf <= step && !is_pop && enq && (count == FullCnt);
      out_empty <= count_next == '0;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.payload.key_out = out_popped ? rd_data : 16'h0000;
  assign rsp.payload.key_valid = out_popped;
  assign rsp.payload.queue_empty = out_empty;
  assign rsp.payload.key_queued = out_qd;
  assign rsp.payload.overflow = out_ovf;

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("entry count beyond depth");
  a_no_both: assert property (@(posedge clk) disable iff (rst) !(do_wr && do_rd))
    else $error("read and write in one request");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> $stable(out_qd) && $stable(out_popped))
    else $error("response changed while stalled");
endmodule
`default_nettype wire
